### hw/rtl/nss_pkg.sv
`timescale 1ns / 1ps

package nss_pkg;

  // Default sizes of the site table and of one coordinate.
  localparam int MAX_SITES_DEF  = 256;
  localparam int COORD_BITS_DEF = 24;

  // Fixed widths of the transaction fields.
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 8;
  localparam int DIST_W   = 49;

  // Largest reportable squared distance, and the cap of one squared axis term.
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [63:0]       TERM_CAP = 64'h4000_0000_0000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // Width of one squared axis term. Beyond 31 magnitude bits the term is capped at 2^62.
  function automatic int term_width(input int coord_bits);
    return (coord_bits > 31) ? 63 : 2 * coord_bits;
  endfunction

endpackage

### hw/rtl/nss_cmd_if.sv
`timescale 1ns / 1ps

// Command channel: one transaction clears, appends or queries.
interface nss_cmd_if #(
  parameter int COORD_BITS = nss_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [nss_pkg::OP_W-1:0]      op;
  logic signed [COORD_BITS-1:0]  point_x;
  logic signed [COORD_BITS-1:0]  point_y;

  modport source (output valid, op, point_x, point_y, input ready);
  modport sink   (input valid, op, point_x, point_y, output ready);
endinterface

### hw/rtl/nss_res_if.sv
`timescale 1ns / 1ps

// Result channel: one transaction per command.
interface nss_res_if;
  logic                            valid;
  logic                            ready;
  logic [nss_pkg::STATUS_W-1:0]    status;
  logic [nss_pkg::INDEX_W-1:0]     site_index;
  logic [nss_pkg::DIST_W-1:0]      best_distance_sq;

  modport source (output valid, status, site_index, best_distance_sq, input ready);
  modport sink   (input valid, status, site_index, best_distance_sq, output ready);
endinterface

### hw/rtl/nss_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module nss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/nss_dist.sv
`timescale 1ns / 1ps

// Squared distance unit, two stages: squared axis terms, then their sum.
// A tag travels alongside each site so the comparator knows its index.
module nss_dist #(
  parameter int COORD_BITS = nss_pkg::COORD_BITS_DEF,
  parameter int TAG_W      = 9
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic [TAG_W-1:0]                             in_tag,
  input  logic signed [COORD_BITS-1:0]                 px,
  input  logic signed [COORD_BITS-1:0]                 py,
  input  logic signed [COORD_BITS-1:0]                 sx,
  input  logic signed [COORD_BITS-1:0]                 sy,
  output logic                                         out_valid,
  output logic [TAG_W-1:0]                             out_tag,
  output logic [nss_pkg::term_width(COORD_BITS):0]     out_sum
);

  localparam int DW = COORD_BITS + 1;
  localparam int MW = (COORD_BITS > 31) ? 31 : COORD_BITS;
  localparam int TW = nss_pkg::term_width(COORD_BITS);
  localparam int SW = TW + 1;

  logic             v1;
  logic [TAG_W-1:0] tag1;
  logic [TW-1:0]    tx;
  logic [TW-1:0]    ty;

  // Square of the difference on one axis, capped when the magnitude reaches 2^31.
  function automatic logic [TW-1:0] axis_term(input logic signed [COORD_BITS-1:0] a,
                                              input logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        m;
    logic [32:0]          m_ext;
    logic [MW-1:0]        mm;
    logic [2*MW-1:0]      sq;
    d     = DW'(a) - DW'(b);
    m     = d[DW-1] ? DW'(-d) : DW'(d);
    m_ext = 33'(m[COORD_BITS-1:0]);
    mm    = MW'(m[COORD_BITS-1:0]);
    sq    = mm * mm;
    return (m_ext[32:31] != 2'b00) ? TW'(nss_pkg::TERM_CAP) : TW'(sq);
  endfunction

  // Stage one: the two squarers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    tag1 <= in_tag;
    tx   <= axis_term(px, sx);
    ty   <= axis_term(py, sy);
  end

  // Stage two: the sum of both terms at full precision.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    out_tag <= tag1;
    out_sum <= SW'(tx) + SW'(ty);
  end

endmodule

### hw/rtl/nearest_site_search_top.sv
`timescale 1ns / 1ps
// Clear, append and unused commands go to the done state; the result is loaded into the result
// register once that register is free, and only then does the block take the next command.
// Query over N stored sites: the sites are read in order and the result is loaded the same way;
// one site a cycle passes the distance unit.
// A waiting result does not block the next command. Reset (synchronous) empties the table.
module nearest_site_search_top #(
  parameter int MAX_SITES  = nss_pkg::MAX_SITES_DEF,
  parameter int COORD_BITS = nss_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  nss_cmd_if.sink   cmd,
  nss_res_if.source res
);

  localparam int AW    = $clog2(MAX_SITES);
  localparam int CW    = $clog2(MAX_SITES + 1);
  localparam int SW    = nss_pkg::term_width(COORD_BITS) + 1;
  localparam int TAG_W = AW + 1;

  nss_pkg::state_t  state;
  nss_pkg::state_t  state_next;
  nss_pkg::status_t pend_status;

  logic [CW-1:0]                count;
  logic [CW-1:0]                cnt;
  logic signed [COORD_BITS-1:0] qx;
  logic signed [COORD_BITS-1:0] qy;
  logic [SW-1:0]                best;
  logic [AW-1:0]                best_idx;
  logic [63:0]                  best_ext;
  logic [nss_pkg::DIST_W-1:0]   best_sat;

  logic                    accept;
  logic                    load;
  logic                    issue_v;
  logic                    issue_last;
  logic                    ram_we;
  logic [2*COORD_BITS-1:0] ram_rdata;
  logic                    rd_v;
  logic [TAG_W-1:0]        rd_tag;
  logic                    cmp_v;
  logic [TAG_W-1:0]        cmp_tag;
  logic [SW-1:0]           cmp_sum;
  logic                    cmp_last;
  logic [AW-1:0]           cmp_idx;

  logic                           res_valid;
  logic [nss_pkg::STATUS_W-1:0]   res_status;
  logic [nss_pkg::INDEX_W-1:0]    res_idx;
  logic [nss_pkg::DIST_W-1:0]     res_dist;

  // Handshake and sequencing strobes.
  assign cmd.ready  = (state == nss_pkg::S_IDLE);
  assign accept     = cmd.valid && cmd.ready;
  assign load       = (state == nss_pkg::S_DONE) && (!res_valid || res.ready);
  assign issue_v    = (state == nss_pkg::S_SCAN) && (cnt != count);
  assign issue_last = (cnt == CW'(count - 1'b1));
  assign ram_we     = accept && (nss_pkg::op_t'(cmd.op) == nss_pkg::OP_APPEND)
                      && (count < CW'(MAX_SITES));
  assign cmp_last   = cmp_v && cmp_tag[AW];
  assign cmp_idx    = cmp_tag[AW-1:0];

  // The reported distance saturates at the width of the field.
  assign best_ext = 64'(best);
  assign best_sat = (best_ext > 64'(nss_pkg::DIST_MAX)) ? nss_pkg::DIST_MAX
                                                       : best_ext[nss_pkg::DIST_W-1:0];

  assign res.valid            = res_valid;
  assign res.status           = res_status;
  assign res.site_index       = res_idx;
  assign res.best_distance_sq = res_dist;

  // Site table.
  nss_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_SITES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({cmd.point_x, cmd.point_y}),
    .re    (issue_v),
    .raddr (cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared squared distance unit.
  nss_dist #(
    .COORD_BITS (COORD_BITS),
    .TAG_W      (TAG_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v),
    .in_tag    (rd_tag),
    .px        (qx),
    .py        (qy),
    .sx        ($signed(ram_rdata[2*COORD_BITS-1:COORD_BITS])),
    .sy        ($signed(ram_rdata[COORD_BITS-1:0])),
    .out_valid (cmp_v),
    .out_tag   (cmp_tag),
    .out_sum   (cmp_sum)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      nss_pkg::S_IDLE: begin
        if (accept) begin
          if ((nss_pkg::op_t'(cmd.op) == nss_pkg::OP_QUERY) && (count != '0)) begin
            state_next = nss_pkg::S_SCAN;
          end else begin
            state_next = nss_pkg::S_DONE;
          end
        end
      end
      nss_pkg::S_SCAN: begin
        if (cmp_last) begin
          state_next = nss_pkg::S_DONE;
        end
      end
      nss_pkg::S_DONE: begin
        if (load) begin
          state_next = nss_pkg::S_IDLE;
        end
      end
      default: state_next = nss_pkg::S_IDLE;
    endcase
  end

  // Command decode, scan counter, running minimum and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cnt       <= '0;
      rd_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= '0;
        unique case (nss_pkg::op_t'(cmd.op))
          nss_pkg::OP_CLEAR:  count <= '0;
          nss_pkg::OP_APPEND: begin
            if (count < CW'(MAX_SITES)) begin
              count <= count + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (issue_v) begin
        cnt <= cnt + 1'b1;
      end
      rd_v <= issue_v;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end

    // Payload registers.
    if (accept) begin
      qx          <= cmd.point_x;
      qy          <= cmd.point_y;
      best        <= '0;
      best_idx    <= '0;
      pend_status <= nss_pkg::ST_OK;
      unique case (nss_pkg::op_t'(cmd.op))
        nss_pkg::OP_APPEND: begin
          if (count >= CW'(MAX_SITES)) begin
            pend_status <= nss_pkg::ST_FULL;
          end else begin
            best_idx <= count[AW-1:0];
          end
        end
        nss_pkg::OP_QUERY: begin
          if (count == '0) begin
            pend_status <= nss_pkg::ST_EMPTY;
          end
        end
        default: ;
      endcase
    end
    rd_tag <= {issue_last, cnt[AW-1:0]};
    // The first site always wins; later ones only when strictly closer.
    if (cmp_v && ((cmp_idx == '0) || (cmp_sum < best))) begin
      best     <= cmp_sum;
      best_idx <= cmp_idx;
    end
    if (load) begin
      res_status <= pend_status;
      res_idx    <= nss_pkg::INDEX_W'(best_idx);
      res_dist   <= best_sat;
    end
  end

  // Checks on the table bookkeeping and the scan.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SITES))
    else $error("site count exceeds the table depth");

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    issue_v |-> (cnt < count))
    else $error("scan read beyond the stored sites");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_v |-> (state == nss_pkg::S_SCAN))
    else $error("distance result outside a scan");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status == nss_pkg::ST_EMPTY))
      |-> ((res.site_index == '0) && (res.best_distance_sq == '0)))
    else $error("empty table result carries an index or distance");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    cmp_last |=> (state == nss_pkg::S_DONE))
    else $error("scan did not finish on its last site");

endmodule
